// ===== hdl/per_client_reorder_sequencer_top_defines.svh =====
`ifndef PER_CLIENT_REORDER_SEQUENCER_TOP_DEFINES_SVH
`define PER_CLIENT_REORDER_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define PRCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define PRCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/prcs_pkg.sv =====
`default_nettype none

package prcs_pkg;

    // Defaults for the top-level parameters
    localparam int CLIENTS_DEF   = 16;
    localparam int WINDOW_DEF    = 32;
    localparam int SEQ_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int ID_WIDTH  = 4;
    localparam int GN_WIDTH  = 32;
    localparam int LIM_WIDTH = 6;

    localparam logic [LIM_WIDTH-1:0] LIM_RESET = 6'd32;
    localparam logic [GN_WIDTH-1:0]  GN_MAX    = '1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_RELEASED = 2'd0,
        ST_HELD     = 2'd1,
        ST_STALE    = 2'd2,
        ST_OUTSIDE  = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EVAL = 2'd1,
        S_RUN  = 2'd2
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/prcs_state_mem.sv =====
`default_nettype none

module prcs_state_mem #(
    parameter int CLIENTS = 16,
    parameter int DATA_W  = 49,
    parameter int ADDR_W  = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    output logic                   clearing
);

    logic [DATA_W-1:0] mem [CLIENTS];
    logic [DATA_W-1:0] rd_data_reg;
    logic              clr_active_reg;
    logic              clr_active_next;
    logic [ADDR_W-1:0] clr_idx_reg;
    logic [ADDR_W-1:0] clr_idx_next;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;

    // Sweep every entry to zero after reset
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_idx_next    = clr_idx_reg;
        if (clr_active_reg)
        begin
            if (clr_idx_reg == ADDR_W'(CLIENTS - 1))
            begin
                clr_active_next = 1'b0;
            end
            else
            begin
                clr_idx_next = clr_idx_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_idx_reg    <= clr_idx_next;
        end
    end

    // Clear sweep owns the write port while active
    always_comb
    begin
        mem_we    = wr_en;
        mem_waddr = wr_addr;
        mem_wdata = wr_data;
        if (clr_active_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end
    end

    // Write port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clr_active_reg;

endmodule

`default_nettype wire

// ===== hdl/prcs_engine.sv =====
`default_nettype none

module prcs_engine #(
    parameter int CLIENTS   = 16,
    parameter int WINDOW    = 32,
    parameter int SEQ_WIDTH = 16,
    parameter int ADDR_W    = 4,
    parameter int DATA_W    = 49
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [prcs_pkg::ID_WIDTH-1:0]  client_id,
    input  wire logic [SEQ_WIDTH-1:0]           req_seq,
    input  wire logic [prcs_pkg::LIM_WIDTH-1:0] window_limit,
    output logic                                busy,
    input  wire logic                           clearing,
    output logic                                rd_en,
    output logic      [ADDR_W-1:0]              rd_addr,
    input  wire logic [DATA_W-1:0]              rd_data,
    output logic                                wr_en,
    output logic      [ADDR_W-1:0]              wr_addr,
    output logic      [DATA_W-1:0]              wr_data,
    output logic                                out_valid,
    output logic      [prcs_pkg::ID_WIDTH-1:0]  out_client,
    output logic      [SEQ_WIDTH-1:0]           out_seq,
    output logic      [prcs_pkg::GN_WIDTH-1:0]  global_number,
    output logic      [1:0]                     status,
    output logic                                last
);

    import prcs_pkg::*;

    localparam int DW = (SEQ_WIDTH > LIM_WIDTH) ? SEQ_WIDTH : LIM_WIDTH;

    state_t                 state_reg;
    state_t                 state_next;
    logic                   accept;
    logic [ID_WIDTH-1:0]    cl_reg;
    logic [SEQ_WIDTH-1:0]   seq_reg;
    logic                   oob_reg;
    logic [SEQ_WIDTH-1:0]   w_last_reg;
    logic [SEQ_WIDTH-1:0]   w_last_next;
    logic [WINDOW-1:0]      w_map_reg;
    logic [WINDOW-1:0]      w_map_next;
    logic [GN_WIDTH-1:0]    gcount_reg;
    logic [GN_WIDTH-1:0]    gcount_next;
    logic [GN_WIDTH-1:0]    gcount_inc;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [SEQ_WIDTH-1:0]   out_seq_reg;
    logic [SEQ_WIDTH-1:0]   out_seq_next;
    logic [ID_WIDTH-1:0]    out_client_reg;
    logic [GN_WIDTH-1:0]    gn_reg;
    logic [GN_WIDTH-1:0]    gn_next;
    status_t                status_reg;
    status_t                status_next;
    logic                   last_reg;
    logic                   last_next;

    logic                   ent_seen;
    logic [SEQ_WIDTH-1:0]   ent_last;
    logic [WINDOW-1:0]      ent_map;
    logic [LIM_WIDTH-1:0]   lim;
    logic [SEQ_WIDTH-1:0]   seq_dist;
    logic [SEQ_WIDTH-1:0]   dist_m1;
    logic [WINDOW-1:0]      hold_mask;
    logic [SEQ_WIDTH-1:0]   run_last;
    logic [WINDOW-1:0]      run_map;

    logic                   dec_release;
    logic                   dec_run;
    logic                   dec_write;
    status_t                dec_status;
    logic                   dec_last;
    logic [SEQ_WIDTH-1:0]   dec_seq;
    logic [SEQ_WIDTH-1:0]   upd_last;
    logic [WINDOW-1:0]      upd_map;

    assign busy   = (state_reg != S_IDLE) || clearing;
    assign accept = start && !busy;

    // Issue the state read at the transfer
    assign rd_en   = accept;
    assign rd_addr = ADDR_W'(client_id);

    // Unpack the entry
    assign ent_seen = rd_data[DATA_W-1];
    assign ent_last = rd_data[DATA_W-2 -: SEQ_WIDTH];
    assign ent_map  = rd_data[WINDOW-1:0];

    // Clamp the window register into 1..WINDOW
    always_comb
    begin
        lim = window_limit;
        if (window_limit == '0)
        begin
            lim = LIM_WIDTH'(1);
        end
        else if (window_limit > LIM_WIDTH'(WINDOW))
        begin
            lim = LIM_WIDTH'(WINDOW);
        end
    end

    assign seq_dist  = seq_reg - ent_last;
    assign dist_m1   = seq_dist - SEQ_WIDTH'(1);
    assign hold_mask = WINDOW'(1) << dist_m1;
    assign run_last  = w_last_reg + SEQ_WIDTH'(1);
    assign run_map   = w_map_reg >> 1;

    assign gcount_inc = (gcount_reg == GN_MAX) ? GN_WIDTH'(1) : gcount_reg + GN_WIDTH'(1);

    // Decide the outcome of the current cycle
    always_comb
    begin
        dec_release = 1'b0;
        dec_run     = 1'b0;
        dec_write   = 1'b0;
        dec_status  = ST_OUTSIDE;
        dec_last    = 1'b1;
        dec_seq     = seq_reg;
        upd_last    = ent_last;
        upd_map     = ent_map;
        case (state_reg)
            S_EVAL:
            begin
                if (oob_reg)
                begin
                    dec_status = ST_OUTSIDE;
                end
                else if (!ent_seen)
                begin
                    dec_release = 1'b1;
                    dec_write   = 1'b1;
                    dec_status  = ST_RELEASED;
                    upd_last    = seq_reg;
                    upd_map     = '0;
                end
                else if ((seq_dist == '0) || seq_dist[SEQ_WIDTH-1])
                begin
                    dec_status = ST_STALE;
                end
                else if (DW'(seq_dist) > DW'(lim))
                begin
                    dec_status = ST_OUTSIDE;
                end
                else if (seq_dist == SEQ_WIDTH'(1))
                begin
                    dec_release = 1'b1;
                    dec_status  = ST_RELEASED;
                    upd_last    = seq_reg;
                    upd_map     = ent_map >> 1;
                    dec_last    = !upd_map[0];
                    dec_run     = upd_map[0];
                    dec_write   = !upd_map[0];
                end
                else if ((ent_map & hold_mask) != '0)
                begin
                    dec_status = ST_STALE;
                end
                else
                begin
                    dec_write  = 1'b1;
                    dec_status = ST_HELD;
                    upd_map    = ent_map | hold_mask;
                end
            end
            S_RUN:
            begin
                dec_release = 1'b1;
                dec_status  = ST_RELEASED;
                dec_seq     = run_last;
                upd_last    = run_last;
                upd_map     = run_map;
                dec_last    = !run_map[0];
                dec_run     = run_map[0];
                dec_write   = !run_map[0];
            end
            default:
            begin
                dec_last = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL, S_RUN:
            begin
                state_next = dec_run ? S_RUN : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs and working state
    always_comb
    begin
        out_valid_next = 1'b0;
        out_seq_next   = out_seq_reg;
        gn_next        = gn_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        gcount_next    = gcount_reg;
        w_last_next    = w_last_reg;
        w_map_next     = w_map_reg;
        case (state_reg)
            S_EVAL, S_RUN:
            begin
                out_valid_next = 1'b1;
                out_seq_next   = dec_seq;
                status_next    = dec_status;
                last_next      = dec_last;
                gn_next        = dec_release ? gcount_inc : '0;
                gcount_next    = dec_release ? gcount_inc : gcount_reg;
                w_last_next    = upd_last;
                w_map_next     = upd_map;
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    // Write back the entry when an item changes it, once any release run ends
    assign wr_en   = dec_write;
    assign wr_addr = ADDR_W'(cl_reg);
    assign wr_data = {1'b1, upd_last, upd_map};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gcount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gcount_reg    <= gcount_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cl_reg  <= client_id;
            seq_reg <= req_seq;
            oob_reg <= (32'(client_id) >= 32'(CLIENTS));
        end
        if (out_valid_next)
        begin
            out_client_reg <= cl_reg;
        end
        w_last_reg  <= w_last_next;
        w_map_reg   <= w_map_next;
        out_seq_reg <= out_seq_next;
        gn_reg      <= gn_next;
        status_reg  <= status_next;
        last_reg    <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_client    = out_client_reg;
    assign out_seq       = out_seq_reg;
    assign global_number = gn_reg;
    assign status        = status_reg;
    assign last          = last_reg;

endmodule

`default_nettype wire

// ===== hdl/per_client_reorder_sequencer_top.sv =====
`default_nettype none

// Channel   Direction  Transfer condition         Signals
// request   in         start && !busy             client_id, req_seq
// result    out        out_valid (one cycle)      out_client, out_seq, global_number,
//                                                 status, last
// config    in         window_limit_we            window_limit_wdata
//
// A request that causes one result passes through the state memory read,
// then one state that evaluates, emits and writes the entry back.
// A release run emits one result per held successor, up to WINDOW results.
// After reset the state memory is swept to zero, one entry at a time; busy
// stays high during the sweep. Results cannot be stalled by the receiver.

module per_client_reorder_sequencer_top #(
    parameter int CLIENTS   = prcs_pkg::CLIENTS_DEF,
    parameter int WINDOW    = prcs_pkg::WINDOW_DEF,
    parameter int SEQ_WIDTH = prcs_pkg::SEQ_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [prcs_pkg::ID_WIDTH-1:0]  client_id,
    input  wire logic [SEQ_WIDTH-1:0]           req_seq,
    input  wire logic                           window_limit_we,
    input  wire logic [prcs_pkg::LIM_WIDTH-1:0] window_limit_wdata,
    output logic                                out_valid,
    output logic      [prcs_pkg::ID_WIDTH-1:0]  out_client,
    output logic      [SEQ_WIDTH-1:0]           out_seq,
    output logic      [prcs_pkg::GN_WIDTH-1:0]  global_number,
    output logic      [1:0]                     status,
    output logic                                last
);

    import prcs_pkg::*;

    `include "per_client_reorder_sequencer_top_defines.svh"

    localparam int ADDR_W = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int DATA_W = 1 + SEQ_WIDTH + WINDOW;

    logic [LIM_WIDTH-1:0] window_limit_reg;
    logic [LIM_WIDTH-1:0] window_limit_next;
    logic                 clearing;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic [DATA_W-1:0]    rd_data;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [DATA_W-1:0]    wr_data;

    // Window register
    assign window_limit_next = window_limit_we ? window_limit_wdata : window_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_limit_reg <= LIM_RESET;
        end
        else
        begin
            window_limit_reg <= window_limit_next;
        end
    end

    prcs_state_mem #(
        .CLIENTS (CLIENTS),
        .DATA_W  (DATA_W),
        .ADDR_W  (ADDR_W)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .clearing (clearing)
    );

    prcs_engine #(
        .CLIENTS   (CLIENTS),
        .WINDOW    (WINDOW),
        .SEQ_WIDTH (SEQ_WIDTH),
        .ADDR_W    (ADDR_W),
        .DATA_W    (DATA_W)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .client_id     (client_id),
        .req_seq       (req_seq),
        .window_limit  (window_limit_reg),
        .busy          (busy),
        .clearing      (clearing),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .out_valid     (out_valid),
        .out_client    (out_client),
        .out_seq       (out_seq),
        .global_number (global_number),
        .status        (status),
        .last          (last)
    );

    // Checks
    `PRCS_ASSERT_NOW(a_gn_zero_unless_release, out_valid && (status != ST_RELEASED), global_number == '0, "global number on a non-release result")
    `PRCS_ASSERT_NEXT(a_busy_after_transfer, start && !busy, busy, "busy not raised after a transfer")
    `PRCS_ASSERT_NEXT(a_run_continues, out_valid && !last, out_valid, "gap inside a release run")
    `PRCS_ASSERT_NEXT(a_gap_after_last, out_valid && last, !out_valid, "result without a request after last")

endmodule

`default_nettype wire

// ===== tb/tb_per_client_reorder_sequencer_top.sv =====
`default_nettype none

module tb_per_client_reorder_sequencer_top;
    import prcs_pkg::*;

    localparam int N_CLIENTS      = CLIENTS_DEF;
    localparam int WIN            = WINDOW_DEF;
    localparam int SEQ_W          = SEQ_WIDTH_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int REPORT_LIMIT   = 200;

    typedef struct packed {
        logic [ID_WIDTH-1:0] client;
        logic [SEQ_W-1:0]    seq;
        logic [GN_WIDTH-1:0] gnum;
        status_t             st;
        logic                fin;
    } seq_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [ID_WIDTH-1:0]   client_id;
    logic [SEQ_W-1:0]      req_seq;
    logic                  window_limit_we;
    logic [LIM_WIDTH-1:0]  window_limit_wdata;
    logic                  out_valid;
    logic [ID_WIDTH-1:0]   out_client;
    logic [SEQ_W-1:0]      out_seq;
    logic [GN_WIDTH-1:0]   global_number;
    logic [1:0]            status;
    logic                  last;

    // Shadow state of the sequencer
    logic                  client_known [N_CLIENTS];
    logic [SEQ_W-1:0]      client_last  [N_CLIENTS];
    logic [WIN-1:0]        client_held  [N_CLIENTS];
    logic [GN_WIDTH-1:0]   gnum_counter;
    logic [LIM_WIDTH-1:0]  window_reg;

    seq_result_t           pending_results[$];
    seq_result_t           head_result;
    int                    mismatches;
    int                    items_sent;
    int                    idle_pct;
    int                    idle_cycles;

    per_client_reorder_sequencer_top u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .client_id          (client_id),
        .req_seq            (req_seq),
        .window_limit_we    (window_limit_we),
        .window_limit_wdata (window_limit_wdata),
        .out_valid          (out_valid),
        .out_client         (out_client),
        .out_seq            (out_seq),
        .global_number      (global_number),
        .status             (status),
        .last               (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int effective_window();
        int lim;
        lim = window_reg;
        if (lim == 0)
            lim = 1;
        if (lim > WIN)
            lim = WIN;
        return lim;
    endfunction

    // Advance the global counter, wrapping from max back to 1
    function automatic logic [GN_WIDTH-1:0] next_global_number();
        if (gnum_counter == GN_MAX)
            gnum_counter = 1;
        else
            gnum_counter = gnum_counter + 1'b1;
        return gnum_counter;
    endfunction

    function automatic void push_result(input logic [ID_WIDTH-1:0] cid,
                                        input logic [SEQ_W-1:0] seq,
                                        input logic [GN_WIDTH-1:0] gn,
                                        input status_t st, input logic fin);
        seq_result_t r;
        r.client = cid;
        r.seq    = seq;
        r.gnum   = gn;
        r.st     = st;
        r.fin    = fin;
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Compute the results of one accepted request and update the shadow state
    function automatic void predict_results(input logic [ID_WIDTH-1:0] cid,
                                            input logic [SEQ_W-1:0] seq);
        logic [SEQ_W-1:0] seq_dist;
        int               lim;
        int               n;
        logic             run_more;
        lim = effective_window();
        if (!client_known[cid])
        begin
            client_known[cid] = 1'b1;
            client_last[cid]  = seq;
            client_held[cid]  = '0;
            push_result(cid, seq, next_global_number(), ST_RELEASED, 1'b1);
            return;
        end
        seq_dist = seq - client_last[cid];
        if (seq_dist == 0 || seq_dist[SEQ_W-1])
        begin
            push_result(cid, seq, '0, ST_STALE, 1'b1);
        end
        else if (seq_dist > lim)
        begin
            push_result(cid, seq, '0, ST_OUTSIDE, 1'b1);
        end
        else if (seq_dist == 1)
        begin
            // release in order, then drain the run of held successors
            client_last[cid] = seq;
            client_held[cid] = client_held[cid] >> 1;
            run_more = client_held[cid][0];
            push_result(cid, seq, next_global_number(), ST_RELEASED, !run_more);
            n = 1;
            while (run_more)
            begin
                client_last[cid] = client_last[cid] + 1'b1;
                client_held[cid] = client_held[cid] >> 1;
                n++;
                run_more = client_held[cid][0] && (n < WIN);
                push_result(cid, client_last[cid], next_global_number(), ST_RELEASED,
                            !run_more);
            end
        end
        else if (client_held[cid][seq_dist-1])
        begin
            push_result(cid, seq, '0, ST_STALE, 1'b1);
        end
        else
        begin
            client_held[cid][seq_dist-1] = 1'b1;
            push_result(cid, seq, '0, ST_HELD, 1'b1);
        end
    endfunction

    // Present one request, with random idle cycles ahead of it, until transfer
    task automatic send_request(input logic [ID_WIDTH-1:0] cid, input logic [SEQ_W-1:0] seq);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        start      <= 1'b1;
        client_id  <= cid;
        req_seq    <= seq;
        do
            @(posedge clk);
        while (busy);
        predict_results(cid, seq);
        items_sent++;
    endtask

    // Drop start and hold until every expected result has come and the block is idle
    task automatic wait_quiet();
        start <= 1'b0;
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_window(input logic [LIM_WIDTH-1:0] val);
        wait_quiet();
        window_limit_we    <= 1'b1;
        window_limit_wdata <= val;
        @(posedge clk);
        window_reg = val;
        window_limit_we <= 1'b0;
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result, expected none, actual client %0h seq %0h",
                             $time, out_client, out_seq);
            end
            else
            begin
                head_result = pending_results.pop_front();
                check_field("out_client", 32'(head_result.client), 32'(out_client));
                check_field("out_seq", 32'(head_result.seq), 32'(out_seq));
                check_field("global_number", head_result.gnum, global_number);
                check_field("status", 32'(head_result.st), 32'(status));
                check_field("last", 32'(head_result.fin), 32'(last));
            end
        end
    end

    // End the run when nothing transfers for too long
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || out_valid || window_limit_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // First requests, sequence wrap, duplicates and stale numbers
    task automatic test_first_and_stale();
        send_request(4'd0, 16'hFFFF);
        send_request(4'd0, 16'h0000);
        send_request(4'd0, 16'h0000);
        send_request(4'd0, 16'h8000);
        send_request(4'd0, 16'hFFFF);
        send_request(4'd0, 16'h7FFF);
        send_request(4'd15, 16'h0000);
    endtask

    // Gaps held, held duplicates dropped, window edge, release run
    task automatic test_hold_and_run();
        send_request(4'd15, 16'd3);
        send_request(4'd15, 16'd3);
        send_request(4'd15, 16'd2);
        send_request(4'd15, 16'd32);
        send_request(4'd15, 16'd33);
        send_request(4'd15, 16'd1);
    endtask

    // Window register at zero, above the maximum and at one
    task automatic test_window_extremes();
        write_window(6'd0);
        send_request(4'd0, 16'd2);
        send_request(4'd0, 16'd1);
        write_window(6'd63);
        send_request(4'd0, 16'd33);
        send_request(4'd0, 16'd34);
        write_window(6'd1);
        send_request(4'd0, 16'd3);
        send_request(4'd0, 16'd2);
    endtask

    // Numbers held beyond a lowered window are kept and released by the run
    task automatic test_window_lowered();
        write_window(LIM_RESET);
        send_request(4'd5, 16'd100);
        send_request(4'd5, 16'd106);
        write_window(6'd2);
        send_request(4'd5, 16'd102);
        send_request(4'd5, 16'd101);
        send_request(4'd5, 16'd103);
        send_request(4'd5, 16'd104);
        send_request(4'd5, 16'd105);
    endtask

    // Mostly shuffled in-window bursts per client, the rest noise
    task automatic run_random_phase(input int idle, input logic [LIM_WIDTH-1:0] win,
                                    input int count);
        int               target;
        int               lim;
        int               burst_len;
        int               offs[WIN];
        int               j;
        int               k;
        int               tmp;
        logic [ID_WIDTH-1:0] cid;
        logic [SEQ_W-1:0] base;
        logic [SEQ_W-1:0] seq_v;
        logic [31:0]      rnd;
        write_window(win);
        idle_pct = idle;
        target = items_sent + count;
        lim = effective_window();
        while (items_sent < target)
        begin
            cid  = ID_WIDTH'($urandom_range(N_CLIENTS - 1));
            base = client_last[cid];
            rnd  = $urandom;
            if (!client_known[cid])
            begin
                send_request(cid, rnd[SEQ_W-1:0]);
            end
            else if ($urandom_range(9) < 7)
            begin
                if ($urandom_range(7) == 0)
                    burst_len = lim;
                else
                    burst_len = $urandom_range(1, (lim < 6) ? lim : 6);
                for (j = 0; j < burst_len; j++)
                    offs[j] = j + 1;
                for (j = burst_len - 1; j > 0; j--)
                begin
                    k = $urandom_range(j);
                    tmp = offs[j];
                    offs[j] = offs[k];
                    offs[k] = tmp;
                end
                // often send the in-order number last to force the longest run
                if ($urandom_range(1) == 1)
                begin
                    for (j = 0; j < burst_len; j++)
                        if (offs[j] == 1)
                            k = j;
                    offs[k] = offs[burst_len-1];
                    offs[burst_len-1] = 1;
                end
                for (j = 0; j < burst_len; j++)
                begin
                    seq_v = base + SEQ_W'(offs[j]);
                    send_request(cid, seq_v);
                end
            end
            else
            begin
                case ($urandom_range(3))
                    0: seq_v = rnd[SEQ_W-1:0];
                    1: seq_v = base - SEQ_W'($urandom_range(40));
                    2: seq_v = base + SEQ_W'(lim + 1 + $urandom_range(60));
                    default: seq_v = base + SEQ_W'($urandom_range(1, lim));
                endcase
                send_request(cid, seq_v);
            end
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, LIM_RESET, 48);
        run_random_phase(75, 6'd1, 48);
        run_random_phase(7, 6'd63, 48);
        run_random_phase(0, LIM_WIDTH'($urandom_range(2, 31)), 48);
        run_random_phase(75, 6'd0, 48);
        run_random_phase(7, LIM_WIDTH'($urandom_range(2, 31)), 48);
    endtask

    initial
    begin
        for (int i = 0; i < N_CLIENTS; i++)
        begin
            client_known[i] = 1'b0;
            client_last[i]  = '0;
            client_held[i]  = '0;
        end
        gnum_counter = '0;
        window_reg   = LIM_RESET;
        mismatches   = 0;
        items_sent   = 0;
        idle_pct     = 0;
        rst_n              <= 1'b0;
        start              <= 1'b0;
        client_id          <= '0;
        req_seq            <= '0;
        window_limit_we    <= 1'b0;
        window_limit_wdata <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_first_and_stale();
        test_hold_and_run();
        test_window_extremes();
        test_window_lowered();
        test_random_traffic();

        // drain, then watch for stray results
        wait_quiet();
        repeat (2 * WIN) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
